### hdl/a85_pkg.sv
`timescale 1ns / 1ps

package a85_pkg;

  localparam int DIGIT_W     = 7;
  localparam int GROUP_CHARS = 5;
  localparam int CELLS       = 4;   // divide-by-85 steps; the last quotient is the top digit
  localparam int CNT_W       = 3;

  // floor(v / 85) == (v * RECIP) >> RECIP_SHIFT for every 32-bit v
  localparam logic [31:0] RECIP       = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;

  localparam logic [DIGIT_W-1:0] CHAR_OFFSET = 7'd33;
  localparam logic [DIGIT_W-1:0] Z_CHAR      = 7'd122;

  localparam logic [CNT_W-1:0] EMIT_Z    = 3'd1;
  localparam logic [CNT_W-1:0] EMIT_FULL = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] count;   // characters to send for this group
    logic             zero;    // full all-zero group, sent as 'z'
    logic             eom;     // group closes the message
  } a85_meta_t;

  typedef struct packed {
    logic [31:0]              value;   // value still to be split up
    logic [CELLS*DIGIT_W-1:0] digits;  // digits found so far, newest on top
    a85_meta_t                meta;
  } a85_link_t;

endpackage

### hdl/a85_pack.sv
`timescale 1ns / 1ps

module a85_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_eom,
  output logic                 out_valid,
  input  logic                 out_ready,
  output a85_pkg::a85_link_t   out_data
);

  logic [23:0] acc;
  logic [1:0]  cnt;
  logic        valid;
  a85_pkg::a85_link_t grp;

  logic        full;
  logic        close;
  logic [31:0] value_next;
  a85_pkg::a85_meta_t meta_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = grp;

  assign full  = (cnt == 2'd3);
  assign close = full || in_eom;

  // left-align the group, zero padding the missing bytes
  always_comb begin
    case (cnt)
      2'd0:    value_next = {in_byte, 24'd0};
      2'd1:    value_next = {acc[7:0], in_byte, 16'd0};
      2'd2:    value_next = {acc[15:0], in_byte, 8'd0};
      default: value_next = {acc, in_byte};
    endcase
    meta_next.zero  = full && (value_next == 32'd0);
    meta_next.eom   = in_eom;
    if (meta_next.zero) begin
      meta_next.count = a85_pkg::EMIT_Z;
    end else if (full) begin
      meta_next.count = a85_pkg::EMIT_FULL;
    end else begin
      meta_next.count = 3'(cnt) + 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= 2'd0;
      valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (close) begin
          cnt   <= 2'd0;
          valid <= 1'b1;
        end else begin
          cnt   <= cnt + 2'd1;
          valid <= 1'b0;
        end
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc <= {acc[15:0], in_byte};
      if (close) begin
        grp.value  <= value_next;
        grp.digits <= '0;
        grp.meta   <= meta_next;
      end
    end
  end

endmodule

### hdl/a85_cell.sv
`timescale 1ns / 1ps

module a85_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  a85_pkg::a85_link_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output a85_pkg::a85_link_t   out_data
);

  logic                                        valid;
  logic [31:0]                                 quot;
  logic [a85_pkg::DIGIT_W-1:0]                 low;
  logic [a85_pkg::CELLS*a85_pkg::DIGIT_W-1:0]  digits;
  a85_pkg::a85_meta_t                          meta;

  logic [63:0]                  prod;
  logic [a85_pkg::DIGIT_W-1:0]  q85;
  logic [a85_pkg::DIGIT_W-1:0]  rem;

  assign prod = 64'(in_data.value) * 64'(a85_pkg::RECIP);

  // remainder is below 85, so seven low bits of v - 85*q are enough
  assign q85 = (quot[6:0] << 6) + (quot[6:0] << 4) + (quot[6:0] << 2) + quot[6:0];
  assign rem = low - q85;

  assign in_ready        = !valid || out_ready;
  assign out_valid       = valid;
  assign out_data.value  = quot;
  assign out_data.digits = {rem, digits[a85_pkg::CELLS*a85_pkg::DIGIT_W-1:a85_pkg::DIGIT_W]};
  assign out_data.meta   = meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      quot   <= 32'(prod >> a85_pkg::RECIP_SHIFT);
      low    <= in_data.value[a85_pkg::DIGIT_W-1:0];
      digits <= in_data.digits;
      meta   <= in_data.meta;
    end
  end

endmodule

### hdl/a85_ser.sv
`timescale 1ns / 1ps

module a85_ser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  a85_pkg::a85_link_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [a85_pkg::DIGIT_W-1:0] out_char,
  output logic                        group_last,
  output logic                        message_last
);

  logic                                                   busy;
  logic [a85_pkg::CNT_W-1:0]                              left;
  logic                                                   eom;
  logic [a85_pkg::GROUP_CHARS-1:0][a85_pkg::DIGIT_W-1:0]  chars;

  logic [a85_pkg::GROUP_CHARS-1:0][a85_pkg::DIGIT_W-1:0]  dig;
  logic [a85_pkg::GROUP_CHARS-1:0][a85_pkg::DIGIT_W-1:0]  load;
  logic                                                   last;

  // top entry is the most significant digit
  assign dig = {in_data.value[a85_pkg::DIGIT_W-1:0], in_data.digits};

  always_comb begin
    for (int i = 0; i < a85_pkg::GROUP_CHARS; i++) begin
      load[i] = dig[i] + a85_pkg::CHAR_OFFSET;
    end
    if (in_data.meta.zero) begin
      load[a85_pkg::GROUP_CHARS-1] = a85_pkg::Z_CHAR;
    end
  end

  assign last         = (left == 3'd1);
  assign in_ready     = !busy || (out_ready && last);
  assign out_valid    = busy;
  assign out_char     = chars[a85_pkg::GROUP_CHARS-1];
  assign group_last   = last;
  assign message_last = last && eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      left <= in_data.meta.count;
    end else if (busy && out_ready) begin
      busy <= !last;
      left <= left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chars <= load;
      eom   <= in_data.meta.eom;
    end else if (busy && out_ready) begin
      chars <= {chars[a85_pkg::GROUP_CHARS-2:0], 7'd0};
    end
  end

endmodule

### hdl/ascii85_stream_encoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                      Payload
// --------  ---  ---------------------------  ------------------------------------
// s (in)    in   s_tvalid s_tready s_tdata    tdata: data_byte; tlast: end_of_message
//                s_tlast
// m (out)   out  m_tvalid m_tready m_tdata    tdata: out_char + zero bit; tuser:
//                m_tuser m_tlast              group_last; tlast: message_last
//
// Bytes enter whenever the group register ahead of the divider chain is free.
// A closed group passes the four divide-by-85 cell registers, and the character
// register then sends one character per cycle while m_tready is high; a full
// group yields five characters, or one 'z' if all zero. rst (sync) drops all
// groups in flight. Stalls on m_tready back up through the chain to s_tready;
// no data is lost.

module ascii85_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tuser,   // [0] group_last
  output logic       m_tlast    // message_last
);

  // link[0] leaves the byte packer, link[CELLS] enters the serializer
  a85_pkg::a85_link_t link       [a85_pkg::CELLS+1];
  logic               link_valid [a85_pkg::CELLS+1];
  logic               link_ready [a85_pkg::CELLS+1];

  logic [a85_pkg::DIGIT_W-1:0] out_char;

  a85_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_eom    (s_tlast),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link[0])
  );

  // each cell peels off one base-85 digit, least significant first
  for (genvar i = 0; i < a85_pkg::CELLS; i++) begin : g_cell
    a85_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link[i+1])
    );
  end

  a85_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (link_valid[a85_pkg::CELLS]),
    .in_ready     (link_ready[a85_pkg::CELLS]),
    .in_data      (link[a85_pkg::CELLS]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_char     (out_char),
    .group_last   (m_tuser),
    .message_last (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule
